// ----- hw/rtl/nvq_pkg.sv -----
// Normal vector quantizer: shared types and constants.
// No dependencies.
package nvq_pkg;

    localparam int MAX_LEVELS_DEF     = 8;
    localparam int COMPONENT_BITS_DEF = 16;

    localparam int LVL_W     = 4;
    localparam int IDX_W     = 19;
    localparam int CFG_RESET = 4;

    // Sphere vertices, signed Q1.14
    localparam int VERT_W   = 16;
    localparam int ONE_Q14  = 16384;
    localparam logic [VERT_W-1:0] POS_ONE = VERT_W'(ONE_Q14);
    localparam logic [VERT_W-1:0] NEG_ONE = VERT_W'(-ONE_Q14);

    // Midpoint normalization
    localparam int NORM_W  = 2 * VERT_W;
    localparam int SQ_SHIFT = 28;
    localparam int RAD_W   = NORM_W + SQ_SHIFT;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int NUM_W   = VERT_W + 30;
    localparam int DEN_W   = ROOT_W + 1;
    localparam int QUO_W   = VERT_W;

    typedef logic [2:0][VERT_W-1:0] vert_t;

    typedef struct packed {
        logic start;
        logic busy;
    } unit_ctl_t;

endpackage

// ----- hw/rtl/nvq_if.sv -----
// Request and result channels of the normal vector quantizer.
// Depends on nvq_pkg.
interface nvq_req_if #(parameter int COMPONENT_BITS = nvq_pkg::COMPONENT_BITS_DEF);
    logic                         valid;
    logic                         ready;
    logic [COMPONENT_BITS-1:0]    normal_x;
    logic [COMPONENT_BITS-1:0]    normal_y;
    logic [COMPONENT_BITS-1:0]    normal_z;
    logic [nvq_pkg::LVL_W-1:0]    levels_wanted;

    modport source (output valid, normal_x, normal_y, normal_z, levels_wanted, input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, levels_wanted, output ready);
endinterface

interface nvq_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [nvq_pkg::IDX_W-1:0]    normal_index;
    logic                         no_hit;

    modport source (output valid, normal_index, no_hit, input ready);
    modport sink   (input valid, normal_index, no_hit, output ready);
endinterface

// ----- hw/rtl/nvq_isqrt.sv -----
// Bit-pair integer square root of n * 2^SQ_SHIFT, one step per cycle.
// Depends on nvq_pkg.
module nvq_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [nvq_pkg::NORM_W-1:0]  n,
    output logic                        busy,
    output logic [nvq_pkg::ROOT_W-1:0]  root
);
    import nvq_pkg::*;

    logic [RAD_W-1:0] rem_reg, rem_next;
    logic [RAD_W-1:0] root_reg, root_next;
    logic [RAD_W-1:0] bit_reg, bit_next;
    logic [RAD_W-1:0] trial;

    always_comb
    begin
        trial     = root_reg + bit_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        if (start)
        begin
            rem_next  = {n, {SQ_SHIFT{1'b0}}};
            root_next = '0;
            bit_next  = RAD_W'(1) << (RAD_W - 2);
        end
        else if (|bit_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_next  = rem_reg - trial;
                root_next = (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bit_reg <= '0;
        else
            bit_reg <= bit_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = |bit_reg;
    assign root = root_reg[ROOT_W-1:0];

endmodule

// ----- hw/rtl/nvq_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on nvq_pkg.
module nvq_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [nvq_pkg::NUM_W-1:0]   num,
    input  logic [nvq_pkg::DEN_W-1:0]   den,
    output logic                        busy,
    output logic [nvq_pkg::QUO_W-1:0]   quo
);
    import nvq_pkg::*;

    localparam int DSH_W = DEN_W + QUO_W - 1;
    localparam int WK    = (NUM_W > DSH_W) ? NUM_W : DSH_W;
    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [WK-1:0]    rem_reg, rem_next;
    logic [WK-1:0]    dsh_reg, dsh_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ge;

    always_comb
    begin
        ge       = rem_reg >= dsh_reg;
        rem_next = rem_reg;
        dsh_next = dsh_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = WK'(num);
            dsh_next = WK'(den) << (QUO_W - 1);
            quo_next = '0;
            cnt_next = CNT_W'(QUO_W);
        end
        else if (cnt_reg != '0)
        begin
            if (ge)
                rem_next = rem_reg - dsh_reg;
            quo_next = {quo_reg[QUO_W-2:0], ge};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign busy = cnt_reg != '0;
    assign quo  = quo_reg;

endmodule

// ----- hw/rtl/nvq_mid.sv -----
// Edge midpoint pushed onto the unit sphere: sum of squares on one multiplier,
// then nvq_isqrt and one nvq_div shared over the three components.
module nvq_mid (
    input  logic               clk,
    input  logic               rst_n,
    input  nvq_pkg::unit_ctl_t ctl_in,
    output nvq_pkg::unit_ctl_t ctl_out,
    input  nvq_pkg::vert_t     a,
    input  nvq_pkg::vert_t     b,
    output nvq_pkg::vert_t     m
);
    import nvq_pkg::*;

    localparam int SW = VERT_W + 1;

    typedef enum logic [5:0] {
        MS_IDLE      = 6'b000001,
        MS_SQ        = 6'b000010,
        MS_ROOT_GO   = 6'b000100,
        MS_ROOT_WAIT = 6'b001000,
        MS_DIV_GO    = 6'b010000,
        MS_DIV_WAIT  = 6'b100000
    } mid_state_t;

    mid_state_t         state_reg, state_next;
    logic [1:0]         k_reg, k_next;
    logic [NORM_W-1:0]  n_reg, n_next;
    logic [ROOT_W-1:0]  q_reg, q_next;
    vert_t              m_reg, m_next;

    logic signed [SW-1:0]   s [3];
    logic signed [SW-1:0]   sk;
    logic signed [2*SW-1:0] sq;
    logic [VERT_W-1:0]      mag;
    logic [NUM_W-1:0]       num;
    logic [DEN_W-1:0]       den;
    logic                   rt_start, rt_busy, dv_start, dv_busy;
    logic [ROOT_W-1:0]      root;
    logic [QUO_W-1:0]       quo;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            s[i] = SW'($signed(a[i])) + SW'($signed(b[i]));
    end

    assign sk  = s[k_reg];
    assign sq  = sk * sk;
    assign mag = sk[SW-1] ? VERT_W'(-sk) : VERT_W'(sk);
    assign num = (NUM_W'(mag) << 29) + NUM_W'(q_reg);
    assign den = {q_reg, 1'b0};

    nvq_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rt_start),
        .n     (n_reg),
        .busy  (rt_busy),
        .root  (root)
    );

    nvq_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .num   (num),
        .den   (den),
        .busy  (dv_busy),
        .quo   (quo)
    );

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        q_next     = q_reg;
        m_next     = m_reg;
        rt_start   = 1'b0;
        dv_start   = 1'b0;
        unique case (state_reg)
            MS_IDLE:
            begin
                if (ctl_in.start)
                begin
                    n_next     = '0;
                    k_next     = '0;
                    state_next = MS_SQ;
                end
            end
            MS_SQ:
            begin
                n_next = n_reg + NORM_W'(sq);
                if (k_reg == 2'd2)
                begin
                    k_next     = '0;
                    state_next = MS_ROOT_GO;
                end
                else
                    k_next = k_reg + 1'b1;
            end
            MS_ROOT_GO:
            begin
                rt_start   = 1'b1;
                state_next = MS_ROOT_WAIT;
            end
            MS_ROOT_WAIT:
            begin
                if (!rt_busy)
                begin
                    q_next     = root;
                    state_next = MS_DIV_GO;
                end
            end
            MS_DIV_GO:
            begin
                if (q_reg == '0)
                begin
                    // zero sum: component set to zero
                    m_next[k_reg] = '0;
                    if (k_reg == 2'd2)
                    begin
                        k_next     = '0;
                        state_next = MS_IDLE;
                    end
                    else
                        k_next = k_reg + 1'b1;
                end
                else
                begin
                    dv_start   = 1'b1;
                    state_next = MS_DIV_WAIT;
                end
            end
            MS_DIV_WAIT:
            begin
                if (!dv_busy)
                begin
                    m_next[k_reg] = sk[SW-1] ? (~quo + 1'b1) : quo;
                    k_next        = (k_reg == 2'd2) ? 2'd0 : k_reg + 1'b1;
                    state_next    = (k_reg == 2'd2) ? MS_IDLE : MS_DIV_GO;
                end
            end
            default: state_next = MS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MS_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        q_reg <= q_next;
        m_reg <= m_next;
    end

    assign m             = m_reg;
    assign ctl_out.busy  = state_reg != MS_IDLE;
    assign ctl_out.start = 1'b0;

    always_ff @(posedge clk)
    begin
        if (rst_n && state_reg == MS_SQ && k_reg == 2'd3)
            $error("nvq_mid: component index out of range");
    end

endmodule

// ----- hw/rtl/nvq_tri.sv -----
// Ray-triangle test on one shared multiply-accumulate: det, U and V as triple
// products of the direction with cross products of the edges and v0.
// Depends on nvq_pkg.
module nvq_tri #(
    parameter int COMPONENT_BITS = nvq_pkg::COMPONENT_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  nvq_pkg::unit_ctl_t               ctl_in,
    output nvq_pkg::unit_ctl_t               ctl_out,
    input  logic [2:0][COMPONENT_BITS-1:0]   d,
    input  nvq_pkg::vert_t                   v0,
    input  nvq_pkg::vert_t                   v1,
    input  nvq_pkg::vert_t                   v2,
    output logic                             hit
);
    import nvq_pkg::*;

    localparam int EW    = VERT_W + 1;
    localparam int CW    = 2 * EW + 1;
    localparam int AW    = (COMPONENT_BITS > EW) ? COMPONENT_BITS : EW;
    localparam int PW    = AW + CW;
    localparam int ACC_W = COMPONENT_BITS + CW + 2;
    localparam logic [63:0] DET_EPS =
        ((64'd1 << (COMPONENT_BITS + 27)) + 64'd9999999) / 64'd10000000;
    localparam logic signed [ACC_W+1:0] EPS_W = (ACC_W + 2)'(DET_EPS);

    typedef enum logic [2:0] {
        TS_IDLE = 3'b001,
        TS_RUN  = 3'b010,
        TS_EVAL = 3'b100
    } tri_state_t;

    tri_state_t state_reg, state_next;
    logic [1:0] t_reg, k_reg, g_reg;
    logic [1:0] t_next, k_next, g_next;
    logic       hit_reg, hit_next;

    logic signed [CW-1:0]    c_reg, c_next;
    logic signed [ACC_W-1:0] acc_reg [3];

    logic signed [EW-1:0] e1 [3], e2 [3], w0 [3], pa [3], pb [3];
    logic [1:0]           j, l;
    logic signed [AW-1:0] opa;
    logic signed [CW-1:0] opb;
    logic signed [PW-1:0] prod;

    logic signed [ACC_W+1:0] det_x, u_x, v_x, dp, up, vp;
    logic                    hit_c;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            w0[i] = EW'($signed(v0[i]));
            e1[i] = EW'($signed(v1[i])) - w0[i];
            e2[i] = EW'($signed(v2[i])) - w0[i];
        end
        case (g_reg)
            2'd0:    begin pa = e2; pb = e1; end
            2'd1:    begin pa = w0; pb = e2; end
            default: begin pa = e1; pb = w0; end
        endcase
        case (k_reg)
            2'd0:    begin j = 2'd1; l = 2'd2; end
            2'd1:    begin j = 2'd2; l = 2'd0; end
            default: begin j = 2'd0; l = 2'd1; end
        endcase
        case (t_reg)
            2'd0:    begin opa = AW'(pa[j]); opb = CW'(pb[l]); end
            2'd1:    begin opa = AW'(pa[l]); opb = CW'(pb[j]); end
            default: begin opa = AW'($signed(d[k_reg])); opb = c_reg; end
        endcase
    end

    assign prod = opa * opb;

    always_comb
    begin
        det_x = (ACC_W + 2)'(acc_reg[0]);
        u_x   = (ACC_W + 2)'(acc_reg[1]);
        v_x   = (ACC_W + 2)'(acc_reg[2]);
        dp    = det_x[ACC_W+1] ? -det_x : det_x;
        up    = det_x[ACC_W+1] ? -u_x : u_x;
        vp    = det_x[ACC_W+1] ? -v_x : v_x;
        hit_c = (dp >= EPS_W) && (up >= 0) && (up <= dp) && (vp >= 0)
                && (up + vp <= dp);
    end

    always_comb
    begin
        state_next = state_reg;
        t_next     = t_reg;
        k_next     = k_reg;
        g_next     = g_reg;
        hit_next   = hit_reg;
        c_next     = c_reg;
        unique case (state_reg)
            TS_IDLE:
            begin
                if (ctl_in.start)
                begin
                    t_next     = '0;
                    k_next     = '0;
                    g_next     = '0;
                    state_next = TS_RUN;
                end
            end
            TS_RUN:
            begin
                if (t_reg == 2'd0)
                    c_next = CW'(prod);
                else if (t_reg == 2'd1)
                    c_next = c_reg - CW'(prod);
                if (t_reg == 2'd2)
                begin
                    t_next = '0;
                    if (k_reg == 2'd2)
                    begin
                        k_next = '0;
                        if (g_reg == 2'd2)
                            state_next = TS_EVAL;
                        else
                            g_next = g_reg + 1'b1;
                    end
                    else
                        k_next = k_reg + 1'b1;
                end
                else
                    t_next = t_reg + 1'b1;
            end
            TS_EVAL:
            begin
                hit_next   = hit_c;
                state_next = TS_IDLE;
            end
            default: state_next = TS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= TS_IDLE;
            t_reg     <= '0;
            k_reg     <= '0;
            g_reg     <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            t_reg     <= t_next;
            k_reg     <= k_next;
            g_reg     <= g_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg <= c_next;
        if (state_reg == TS_IDLE && ctl_in.start)
        begin
            for (int i = 0; i < 3; i++)
                acc_reg[i] <= '0;
        end
        else if (state_reg == TS_RUN && t_reg == 2'd2)
            acc_reg[g_reg] <= acc_reg[g_reg] + ACC_W'(prod);
    end

    assign hit           = hit_reg;
    assign ctl_out.busy  = state_reg != TS_IDLE;
    assign ctl_out.start = 1'b0;

endmodule

// ----- hw/rtl/normal_vector_quantizer.sv -----
// Normal vector quantizer top level: request/result channels, level sequencer.
// Depends on nvq_pkg, nvq_if, nvq_mid, nvq_tri.
//
// One request is taken at a time; req.ready is high only while no request is
// in work, and a finished result waits in the output register so the next
// request can be taken meanwhile. A request with zero levels goes straight
// from the level state to finishing. Each level costs three sphere midpoints
// (each paced by the 30-step square root and the 16-step divider, shared over
// the three components) and one to four triangle tests on a single
// multiply-accumulate. After a miss the remaining levels only append a zero
// digit to the index, with no midpoint or triangle work.
module normal_vector_quantizer #(
    parameter int MAX_LEVELS     = nvq_pkg::MAX_LEVELS_DEF,
    parameter int COMPONENT_BITS = nvq_pkg::COMPONENT_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [nvq_pkg::LVL_W-1:0]  cfg_wdata,
    nvq_req_if.sink                    req,
    nvq_rsp_if.source                  rsp
);
    import nvq_pkg::*;

    localparam int IX_W = 3 + 2 * MAX_LEVELS;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_LEVEL    = 7'b0000010,
        ST_MID_GO   = 7'b0000100,
        ST_MID_WAIT = 7'b0001000,
        ST_TRI_GO   = 7'b0010000,
        ST_TRI_WAIT = 7'b0100000,
        ST_FINISH   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [LVL_W-1:0] max_lvl_reg;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    logic [LVL_W-1:0] tgt_reg, tgt_next;
    logic [1:0]       mi_reg, mi_next;
    logic [1:0]       ti_reg, ti_next;
    logic             miss_reg, miss_next;
    logic             rsp_valid_reg, rsp_valid_next;

    logic [2:0][COMPONENT_BITS-1:0] d_reg, d_next;
    vert_t            p1_reg, p2_reg, p3_reg, p1_next, p2_next, p3_next;
    vert_t            mp_reg [3];
    vert_t            mp_next [3];
    logic [IX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0] rsp_idx_reg, rsp_idx_next;
    logic             rsp_miss_reg, rsp_miss_next;

    logic [LVL_W-1:0] want, lv_sel, lv_cap;
    logic [2:0]       octant;
    vert_t            ma, mb, ta, tb, tc, mres;
    unit_ctl_t        mid_ctl_in, mid_ctl_out, tri_ctl_in, tri_ctl_out;
    logic             tri_hit;

    // Level count in use
    always_comb
    begin
        want   = req.levels_wanted;
        lv_sel = (want == '0 || want > max_lvl_reg) ? max_lvl_reg : want;
        lv_cap = (lv_sel > LVL_W'(MAX_LEVELS)) ? LVL_W'(MAX_LEVELS) : lv_sel;
        octant = {req.normal_x[COMPONENT_BITS-1], req.normal_y[COMPONENT_BITS-1],
                  req.normal_z[COMPONENT_BITS-1]};
    end

    always_comb
    begin
        case (mi_reg)
            2'd0:    begin ma = p1_reg; mb = p2_reg; end
            2'd1:    begin ma = p1_reg; mb = p3_reg; end
            default: begin ma = p2_reg; mb = p3_reg; end
        endcase
        case (ti_reg)
            2'd0:    begin ta = p1_reg;    tb = mp_reg[0]; tc = mp_reg[1]; end
            2'd1:    begin ta = mp_reg[0]; tb = p2_reg;    tc = mp_reg[2]; end
            2'd2:    begin ta = mp_reg[0]; tb = mp_reg[1]; tc = mp_reg[2]; end
            default: begin ta = mp_reg[1]; tb = mp_reg[2]; tc = p3_reg;    end
        endcase
    end

    nvq_mid u_mid (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (mid_ctl_in),
        .ctl_out (mid_ctl_out),
        .a       (ma),
        .b       (mb),
        .m       (mres)
    );

    nvq_tri #(
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_tri (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (tri_ctl_in),
        .ctl_out (tri_ctl_out),
        .d       (d_reg),
        .v0      (ta),
        .v1      (tb),
        .v2      (tc),
        .hit     (tri_hit)
    );

    always_comb
    begin
        state_next     = state_reg;
        lvl_next       = lvl_reg;
        tgt_next       = tgt_reg;
        mi_next        = mi_reg;
        ti_next        = ti_reg;
        miss_next      = miss_reg;
        d_next         = d_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        p3_next        = p3_reg;
        mp_next        = mp_reg;
        idx_next       = idx_reg;
        rsp_idx_next   = rsp_idx_reg;
        rsp_miss_next  = rsp_miss_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        mid_ctl_in     = '0;
        tri_ctl_in     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    d_next     = {req.normal_z, req.normal_y, req.normal_x};
                    tgt_next   = lv_cap;
                    lvl_next   = '0;
                    miss_next  = 1'b0;
                    idx_next   = IX_W'(octant);
                    p1_next    = '0;
                    p2_next    = '0;
                    p3_next    = '0;
                    p1_next[2] = octant[0] ? NEG_ONE : POS_ONE;
                    p2_next[0] = octant[2] ? NEG_ONE : POS_ONE;
                    p3_next[1] = octant[1] ? NEG_ONE : POS_ONE;
                    state_next = ST_LEVEL;
                end
            end
            ST_LEVEL:
            begin
                if (lvl_reg == tgt_reg)
                    state_next = ST_FINISH;
                else if (miss_reg)
                begin
                    idx_next = {idx_reg[IX_W-3:0], 2'b00};
                    lvl_next = lvl_reg + 1'b1;
                end
                else
                begin
                    mi_next    = '0;
                    state_next = ST_MID_GO;
                end
            end
            ST_MID_GO:
            begin
                mid_ctl_in.start = 1'b1;
                state_next       = ST_MID_WAIT;
            end
            ST_MID_WAIT:
            begin
                if (!mid_ctl_out.busy)
                begin
                    mp_next[mi_reg] = mres;
                    if (mi_reg == 2'd2)
                    begin
                        ti_next    = '0;
                        state_next = ST_TRI_GO;
                    end
                    else
                    begin
                        mi_next    = mi_reg + 1'b1;
                        state_next = ST_MID_GO;
                    end
                end
            end
            ST_TRI_GO:
            begin
                tri_ctl_in.start = 1'b1;
                state_next       = ST_TRI_WAIT;
            end
            ST_TRI_WAIT:
            begin
                if (!tri_ctl_out.busy)
                begin
                    if (tri_hit)
                    begin
                        case (ti_reg)
                            2'd0:    begin p2_next = mp_reg[0]; p3_next = mp_reg[1]; end
                            2'd1:    begin p1_next = mp_reg[0]; p3_next = mp_reg[2]; end
                            2'd2:
                            begin
                                p1_next = mp_reg[0];
                                p2_next = mp_reg[1];
                                p3_next = mp_reg[2];
                            end
                            default: begin p1_next = mp_reg[1]; p2_next = mp_reg[2]; end
                        endcase
                        idx_next   = {idx_reg[IX_W-3:0], ti_reg};
                        lvl_next   = lvl_reg + 1'b1;
                        state_next = ST_LEVEL;
                    end
                    else if (ti_reg == 2'd3)
                    begin
                        miss_next  = 1'b1;
                        idx_next   = {idx_reg[IX_W-3:0], 2'b00};
                        lvl_next   = lvl_reg + 1'b1;
                        state_next = ST_LEVEL;
                    end
                    else
                    begin
                        ti_next    = ti_reg + 1'b1;
                        state_next = ST_TRI_GO;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_idx_next   = IDX_W'(idx_reg);
                    rsp_miss_next  = miss_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            max_lvl_reg   <= LVL_W'(CFG_RESET);
            lvl_reg       <= '0;
            tgt_reg       <= '0;
            mi_reg        <= '0;
            ti_reg        <= '0;
            miss_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lvl_reg       <= lvl_next;
            tgt_reg       <= tgt_next;
            mi_reg        <= mi_next;
            ti_reg        <= ti_next;
            miss_reg      <= miss_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
                max_lvl_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg        <= d_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        p3_reg       <= p3_next;
        mp_reg       <= mp_next;
        idx_reg      <= idx_next;
        rsp_idx_reg  <= rsp_idx_next;
        rsp_miss_reg <= rsp_miss_next;
    end

    assign req.ready        = state_reg == ST_IDLE;
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.normal_index = rsp_idx_reg;
    assign rsp.no_hit       = rsp_miss_reg;

    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mid_ctl_out.busy && tri_ctl_out.busy))
        else $error("midpoint and triangle units busy together");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lvl_reg <= tgt_reg)
        else $error("level counter past level count");

    a_no_mid_after_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MID_GO) |-> !miss_reg)
        else $error("midpoint started after a miss");

    a_finish_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> (lvl_reg == tgt_reg))
        else $error("finished before all levels");

endmodule
